// ----- rtl/arpb_pkg.sv -----
// ----------------------------------------------------------------------------
// Address range to prefix blocks: shared package
// Widths, defaults, the controller state type and the control structs that
// connect the controller to the datapath.
// ----------------------------------------------------------------------------
package arpb_pkg;

    localparam int ADDR_W_DEF = 32;  // default address width
    localparam int FIELD_W    = 32;  // width of the address fields on the ports
    localparam int PLEN_W     = 6;   // width of the prefix length field

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;  // capture a new range
        logic step;  // emit the current block and advance
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;  // the block computed this cycle closes the range
    } t_sts;

endpackage

// ----- rtl/address_range_to_prefix_blocks.sv -----
// The first block of a range is loaded into the datapath registers, then stepped into the output register.
// A range producing N blocks (1 to 2*ADDRESS_WIDTH-2) is emitted one block per cycle when
// the output is taken at once; the output register sets the pace.
// The next range is accepted the cycle after the final block enters the output register.
// Reset (synchronous, active low) returns the controller to idle and clears output valid.
// ----------------------------------------------------------------------------
// Address range to prefix blocks: top level
// Splits an inclusive address range into the minimal ascending list of
// aligned prefix blocks, one block per output transfer; a start above the end gives one block.
// ----------------------------------------------------------------------------
module address_range_to_prefix_blocks
    import arpb_pkg::*;
#(
    parameter int ADDRESS_WIDTH = ADDR_W_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [FIELD_W-1:0] i_range_start,
    input  logic [FIELD_W-1:0] i_range_end,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [FIELD_W-1:0] o_block_base,
    output logic [PLEN_W-1:0]  o_prefix_len,
    output logic               o_last_block
);

    t_cmd w_cmd;
    t_sts w_sts;

    arpb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    arpb_datapath #(
        .ADDRESS_WIDTH (ADDRESS_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_range_start (i_range_start),
        .i_range_end   (i_range_end),
        .o_block_base  (o_block_base),
        .o_prefix_len  (o_prefix_len),
        .o_last_block  (o_last_block)
    );

endmodule

// ----- rtl/arpb_datapath.sv -----
// ----------------------------------------------------------------------------
// Address range to prefix blocks: datapath
// Holds the current address and the remaining address count, picks the
// largest aligned block that fits, and registers each block for output.
// ----------------------------------------------------------------------------
module arpb_datapath
    import arpb_pkg::*;
#(
    parameter int ADDRESS_WIDTH = ADDR_W_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [FIELD_W-1:0] i_range_start,
    input  logic [FIELD_W-1:0] i_range_end,
    output logic [FIELD_W-1:0] o_block_base,
    output logic [PLEN_W-1:0]  o_prefix_len,
    output logic               o_last_block
);

    localparam int AW = ADDRESS_WIDTH;
    localparam int KW = $clog2(AW + 1);

    logic [AW-1:0]      r_lo;
    logic [AW:0]        r_rem;
    logic [FIELD_W-1:0] r_base;
    logic [PLEN_W-1:0]  r_plen;
    logic               r_last;

    logic [AW-1:0] w_start;
    logic [AW-1:0] w_end;
    logic [AW:0]   w_init_rem;
    logic [AW:0]   w_lo_ext;
    logic [AW:0]   w_lo_low;
    logic [AW:0]   w_smear;
    logic [AW:0]   w_rem_top;
    logic [AW:0]   w_size;
    logic [KW-1:0] w_k;
    logic          w_last;

    assign w_start = i_range_start[AW-1:0];
    assign w_end   = i_range_end[AW-1:0];

    // A range whose start is not below its end yields a single block of one
    // address, so it starts with a remaining count of one.
    always_comb begin
        if (w_start >= w_end) begin
            w_init_rem = (AW + 1)'(1);
        end else begin
            w_init_rem = {1'b0, w_end} - {1'b0, w_start} + (AW + 1)'(1);
        end
    end

    // Alignment limit: the lowest set bit of the address; address zero is
    // aligned to the whole space.
    assign w_lo_ext = {1'b0, r_lo};
    always_comb begin
        if (r_lo == '0) begin
            w_lo_low = {1'b1, {AW{1'b0}}};
        end else begin
            w_lo_low = w_lo_ext & (~w_lo_ext + (AW + 1)'(1));
        end
    end

    // Size limit: the highest set bit of the remaining count.
    always_comb begin
        w_smear = r_rem;
        for (int i = 1; i <= AW; i = i * 2) begin
            w_smear = w_smear | (w_smear >> i);
        end
        w_rem_top = w_smear ^ (w_smear >> 1);
    end

    assign w_size = (w_lo_low < w_rem_top) ? w_lo_low : w_rem_top;
    assign w_last = (r_rem == w_size);

    always_comb begin
        w_k = '0;
        for (int i = 0; i <= AW; i++) begin
            if (w_size[i]) begin
                w_k = w_k | KW'(i);
            end
        end
    end

    assign o_sts.last = w_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lo  <= w_start;
            r_rem <= w_init_rem;
        end else if (i_cmd.step) begin
            r_lo  <= r_lo + w_size[AW-1:0];
            r_rem <= r_rem - w_size;
        end
        if (i_cmd.step) begin
            r_base <= FIELD_W'(r_lo);
            r_plen <= PLEN_W'(AW) - PLEN_W'(w_k);
            r_last <= w_last;
        end
    end

    assign o_block_base = r_base;
    assign o_prefix_len = r_plen;
    assign o_last_block = r_last;

    a_step_rem_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_rem != '0))
        else $error("block emitted with no addresses left");

    a_step_size_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> $onehot(w_size))
        else $error("block size is not a power of two");

    a_step_size_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (w_size <= r_rem))
        else $error("block runs past the end of the range");

endmodule

// ----- rtl/arpb_ctrl.sv -----
// ----------------------------------------------------------------------------
// Address range to prefix blocks: controller
// Sequences one range at a time and owns the output valid flag, stepping the
// datapath while a range runs and the output register is free.
// ----------------------------------------------------------------------------
module arpb_ctrl
    import arpb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_out_free) begin
                    o_cmd.step  = 1'b1;
                    n_out_valid = 1'b1;
                    if (i_sts.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    a_step_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |-> w_out_free)
        else $error("output register overwritten before its transfer");

    a_last_ends_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.step && i_sts.last) |=> (r_state == ST_IDLE))
        else $error("controller kept running after the final block");

    a_step_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |=> o_out_valid)
        else $error("emitted block was not presented");

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// Address range to prefix blocks: testbench top
// Sends inclusive address ranges and checks each prefix block that comes out
// against a predictor that splits the range into aligned blocks. Both sides
// idle at random, and the output is held off once so that the input stalls.
// ----------------------------------------------------------------------------
module tb_top;
    import arpb_pkg::*;

    localparam int AW          = ADDR_W_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 16;
    localparam logic [FIELD_W-1:0] ALL_ONES = '1;

    typedef struct packed {
        logic [FIELD_W-1:0] base;
        logic [PLEN_W-1:0]  plen;
        logic               last;
    } t_prefix_block;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [FIELD_W-1:0] i_range_start = '0;
    logic [FIELD_W-1:0] i_range_end = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [FIELD_W-1:0] o_block_base;
    logic [PLEN_W-1:0]  o_prefix_len;
    logic               o_last_block;

    t_prefix_block blocks_due[$];
    int  error_count    = 0;
    int  ranges_sent    = 0;
    int  blocks_checked = 0;
    int  cycle_count    = 0;
    int  sink_hold      = 0;
    logic hold_request  = 1'b0;
    logic steady        = 1'b0;

    address_range_to_prefix_blocks #(
        .ADDRESS_WIDTH(AW)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_range_start (i_range_start),
        .i_range_end   (i_range_end),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_block_base  (o_block_base),
        .o_prefix_len  (o_prefix_len),
        .o_last_block  (o_last_block)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Each block is the largest aligned block at the current address that
    // still fits below the end of the range.
    function automatic void predict_blocks(input logic [FIELD_W-1:0] s,
                                           input logic [FIELD_W-1:0] e);
        logic [63:0] msk;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] nxt;
        int k;
        int n;
        t_prefix_block b;
        msk = (64'd1 << AW) - 64'd1;
        lo  = {32'd0, s} & msk;
        hi  = {32'd0, e} & msk;
        if (lo >= hi) begin
            b.base = lo[FIELD_W-1:0];
            b.plen = PLEN_W'(AW);
            b.last = 1'b1;
            blocks_due.push_back(b);
        end else begin
            n = 0;
            while (lo <= hi && n < 2 * FIELD_W) begin
                k = 0;
                while (k < AW && (lo & ((64'd1 << (k + 1)) - 64'd1)) == 64'd0
                       && lo + (64'd1 << (k + 1)) - 64'd1 <= hi)
                    k++;
                nxt    = lo + (64'd1 << k);
                b.base = lo[FIELD_W-1:0];
                b.plen = PLEN_W'(AW - k);
                b.last = (nxt > hi);
                blocks_due.push_back(b);
                n++;
                lo = nxt;
            end
        end
    endfunction

    task automatic send_range(input logic [FIELD_W-1:0] s, input logic [FIELD_W-1:0] e);
        while (!steady && $urandom_range(0, 99) < 37) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_range_start <= s;
        i_range_end   <= e;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_blocks(s, e);
        ranges_sent++;
    endtask

    task automatic compare_field(input string name, input logic [FIELD_W-1:0] exp_val,
                                 input logic [FIELD_W-1:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
            error_count++;
        end
    endtask

    // Output side: checks every transfer, then picks the next ready value.
    always @(posedge i_clk) begin : block_sink
        t_prefix_block exp_blk;
        if (o_out_valid === 1'b1 && i_out_ready) begin
            if (blocks_due.size() == 0) begin
                $display("%0t: unexpected block, expected none, actual %h/%0d last %b",
                         $time, o_block_base, o_prefix_len, o_last_block);
                error_count++;
            end else begin
                exp_blk = blocks_due.pop_front();
                compare_field("block_base", exp_blk.base, o_block_base);
                compare_field("prefix_len", FIELD_W'(exp_blk.plen), FIELD_W'(o_prefix_len));
                compare_field("last_block", FIELD_W'(exp_blk.last), FIELD_W'(o_last_block));
                blocks_checked++;
            end
        end
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (sink_hold > 0) begin
            i_out_ready <= 1'b0;
            sink_hold   <= sink_hold - 1;
        end else if (hold_request) begin
            i_out_ready  <= 1'b0;
            sink_hold    <= HOLD_CYCLES;
            hold_request <= 1'b0;
        end else begin
            i_out_ready <= steady || ($urandom_range(0, 99) >= 37);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic test_single_address_blocks();
        send_range(32'h0000_0000, 32'h0000_0000);
        send_range(ALL_ONES, ALL_ONES);
        send_range(ALL_ONES, 32'h0000_0000);
        send_range(32'h0000_0005, 32'h0000_0003);
        send_range(32'hAAAA_AAAA, 32'h5555_5555);
        send_range(32'h1234_5678, 32'h1234_5678);
    endtask

    task automatic test_full_and_halves();
        send_range(32'h0000_0000, ALL_ONES);
        send_range(32'h0000_0000, 32'h7FFF_FFFF);
        send_range(32'h8000_0000, ALL_ONES);
        send_range(32'h0000_0000, 32'h0000_0001);
        send_range(32'h0000_0001, 32'h0000_0002);
        send_range(32'hFFFF_FFFE, ALL_ONES);
        send_range(32'h0A00_0000, 32'h0AFF_FFFF);
    endtask

    // Ranges that need long lists of blocks, up to the longest, sent back to back.
    task automatic test_maximal_split();
        steady <= 1'b1;
        send_range(32'h0000_0001, 32'hFFFF_FFFE);
        send_range(32'h0000_0001, ALL_ONES);
        send_range(32'h0000_0000, 32'hFFFF_FFFE);
        send_range(32'h5555_5555, 32'hAAAA_AAAA);
        send_range(32'h0000_0003, 32'h8000_0004);
        steady <= 1'b0;
    endtask

    // The sink stops taking blocks for a long stretch while ranges keep coming.
    task automatic test_output_stall_fill();
        hold_request <= 1'b1;
        repeat (6) send_range($urandom & 32'h00FF_FFFF, 32'hFF00_0000 | $urandom);
    endtask

    task automatic test_random_ranges(input int count);
        int pick;
        int k;
        logic [63:0] s64;
        logic [63:0] e64;
        logic [FIELD_W-1:0] a;
        logic [FIELD_W-1:0] b;
        for (int i = 0; i < count; i++) begin
            if (i == count / 3) steady <= 1'b1;
            if (i == count / 3 + 40) steady <= 1'b0;
            pick = $urandom_range(0, 99);
            a = $urandom;
            b = $urandom;
            if (pick < 15) begin
                // start not below end
                if (pick < 4) send_range(a, a);
                else if (a >= b) send_range(a, b);
                else send_range(b, a);
            end else if (pick < 40) begin
                e64 = {32'd0, a} + $urandom_range(1, 300);
                if (e64 > {32'd0, ALL_ONES}) e64 = {32'd0, ALL_ONES};
                send_range(a, e64[FIELD_W-1:0]);
            end else if (pick < 65) begin
                // near an aligned block of random size
                k   = $urandom_range(0, 32);
                s64 = {32'd0, a} & ~((64'd1 << k) - 64'd1);
                e64 = s64 + (64'd1 << k) - 64'd1;
                if ($urandom_range(0, 1)) s64 = s64 + $urandom_range(0, 3);
                if ($urandom_range(0, 1)) e64 = e64 - $urandom_range(0, 3);
                if (s64 > {32'd0, ALL_ONES}) s64 = {32'd0, ALL_ONES};
                if (e64 > {32'd0, ALL_ONES}) e64 = {32'd0, ALL_ONES};
                send_range(s64[FIELD_W-1:0], e64[FIELD_W-1:0]);
            end else begin
                if (a < b) send_range(a, b);
                else send_range(b, a);
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_single_address_blocks();
        test_full_and_halves();
        test_maximal_split();
        test_output_stall_fill();
        test_random_ranges(250);
        i_in_valid <= 1'b0;
        while (blocks_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("tb_top: %0d ranges sent, %0d prefix blocks checked", ranges_sent,
                 blocks_checked);
        $display("tb_top: covered single addresses, reversed ranges, full space, %s",
                 "longest splits, output stall and random ranges");
        if (error_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
